[design/bilinear_image_resize_top_macros.svh]
// Assertion macros for the bilinear image resize block.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef BILINEAR_IMAGE_RESIZE_TOP_MACROS_SVH
`define BILINEAR_IMAGE_RESIZE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BIR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bir: assertion failed");
`define BIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bir: assertion failed");
`else
`define BIR_ASSERT_NOW(label, clk, rst, ante, cons)
`define BIR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/bir_pkg.sv]
package bir_pkg;

   localparam int MAX_SIDE = 32;
   localparam int IDX_W    = $clog2(MAX_SIDE);
   localparam int SIDE_W   = 6;
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int PIX_W    = 8;
   localparam int NUM_W    = 12;
   localparam int Q_W      = 16;
   localparam int DIVD_W   = 11 + Q_W;
   localparam int CENT_W   = 21;
   localparam int DVS_W    = SIDE_W + 1;
   localparam int CNT_W    = 5;
   localparam int WGT_W    = 18;
   localparam int OPB_W    = 27;
   localparam int PROD_W   = WGT_W + OPB_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int STEP_W   = 4;
   localparam int AXW_W    = CENT_W + 2;

   localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(DIVD_W - 1);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(8);
   localparam logic [CENT_W-1:0] Q_HALF    = CENT_W'(32768);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH  = 2'd0,
      REG_SOURCE_HEIGHT = 2'd1,
      REG_TARGET_WIDTH  = 2'd2,
      REG_TARGET_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_AXIS,
      ST_MAC,
      ST_DONE
   } state_type;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] side);
      logic [SIDE_W-1:0] v;
      v = side;
      if (side == '0) begin
         v = SIDE_W'(1);
      end else if (side > SIDE_W'(MAX_SIDE)) begin
         v = SIDE_W'(MAX_SIDE);
      end
      return v;
   endfunction

   // Numerator of the centre, (2i+1)*S in Q16.
   function automatic logic [DIVD_W-1:0] centre_dividend(input logic [IDX_W-1:0] idx,
                                                        input logic [SIDE_W-1:0] side);
      logic [NUM_W-1:0] n;
      n = NUM_W'({idx, 1'b1}) * NUM_W'(side);
      return {n[DIVD_W-Q_W-1:0], {Q_W{1'b0}}};
   endfunction

endpackage

[design/bilinear_image_resize_top.sv]
// Bilinear image resizer with a 32 x 32 source image store of 8-bit pixels.
// Request channel (req_*): a word with req_kind low stores req_pixel_in at
// source (req_row, req_col); a word with req_kind high asks for the target pixel
// at (req_row, req_col) and yields one rsp_pixel_out word. Writes yield nothing.
// Sizes are set through the csr_* write port; the user must write them only while
// the block is idle, which the block itself does not enforce. A size of zero counts
// as one and one above 32 counts as 32. The block takes no new word until the
// previous one is finished: a write passes through the check state, and a read
// through the divider and the multiply steps before its word is returned. The pace
// is set by the bit-serial divider, which works out each axis centre in turn; a shared
// 18 x 27 multiplier then forms the weighted sums of the four memory reads.
// A request outside the target size returns zero without entering the divider.
// The result sits in an output register, so a new word is accepted while the
// previous result waits; a stalled receiver holds the block only once a second
// result is ready. Reset restores the default sizes (28 x 28 to 16 x 16) and
// clears all control state; the image store is not cleared and must be written
// before it is read.
`include "bilinear_image_resize_top_macros.svh"

module bilinear_image_resize_top
   import bir_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [IDX_W-1:0]  req_row,
   input  logic [IDX_W-1:0]  req_col,
   input  logic [PIX_W-1:0]  req_pixel_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PIX_W-1:0]  rsp_pixel_out,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [SIDE_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [SIDE_W-1:0] sw_ff, sh_ff, tw_ff, th_ff;
   logic [SIDE_W-1:0] sw_c, sh_c, tw_c, th_c;

   logic              kind_ff;
   logic [IDX_W-1:0]  row_ff, col_ff;
   logic [PIX_W-1:0]  pix_ff;

   logic              axis_ff, axis_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIVD_W-1:0] div_ff, div_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;

   logic [IDX_W-1:0]        h_first_ff, h_second_ff, v_first_ff, v_second_ff;
   logic [IDX_W-1:0]        h_first_in, h_second_in, v_first_in, v_second_in;
   logic signed [WGT_W-1:0] h_wf_ff, h_ws_ff, v_wf_ff, v_ws_ff;
   logic signed [WGT_W-1:0] h_wf_in, h_ws_in, v_wf_in, v_ws_in;

   logic [PIX_W-1:0]         mem_q_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [OPB_W-1:0]  top_ff, top_in;
   logic [PIX_W-1:0]         res_ff, res_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;

   logic [PIX_W-1:0] store [0:(1 << ADDR_W)-1];
   logic              mem_we;
   logic [ADDR_W-1:0] rd_addr;

   logic              req_fire;
   logic [DVS_W-1:0]  divisor;
   logic [SIDE_W-1:0] src_c;
   logic [SIDE_W-1:0] src_m1;
   logic [DVS_W:0]    shifted;
   logic              div_ge;
   logic [DVS_W:0]    div_diff;

   logic [CENT_W-1:0]       cent;
   logic [CENT_W-1:0]       cent_lo;
   logic [CENT_W:0]         cent_hi;
   logic [IDX_W-1:0]        i0_raw, i0_c;
   logic [SIDE_W-1:0]       x1_raw;
   logic [IDX_W-1:0]        x1_c;
   logic signed [AXW_W-1:0] wf_w, ws_w;

   logic signed [WGT_W-1:0] mul_a;
   logic signed [OPB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;

   assign req_fire      = req_valid && req_ready;
   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

   assign sw_c = clamp_side(sw_ff);
   assign sh_c = clamp_side(sh_ff);
   assign tw_c = clamp_side(tw_ff);
   assign th_c = clamp_side(th_ff);

   assign divisor = axis_ff ? {th_c, 1'b0} : {tw_c, 1'b0};
   assign src_c   = axis_ff ? sh_c : sw_c;
   assign src_m1  = src_c - SIDE_W'(1);

   // One restoring division step a cycle; the dividend shifts out as the quotient shifts in.
   assign shifted  = {rem_ff, div_ff[DIVD_W-1]};
   assign div_ge   = (shifted >= {1'b0, divisor});
   assign div_diff = shifted - {1'b0, divisor};

   // Indices and weights of one axis from its Q16 centre.
   assign cent    = div_ff[CENT_W-1:0];
   assign cent_lo = cent - Q_HALF;
   assign cent_hi = {1'b0, cent} + {1'b0, Q_HALF};
   assign i0_raw  = (cent >= Q_HALF) ? cent_lo[CENT_W-1:Q_W] : '0;
   assign x1_raw  = cent_hi[CENT_W:Q_W];
   assign wf_w    = $signed({1'b0, x1_raw, {Q_W{1'b0}}}) - $signed({2'b00, cent})
                    + $signed({2'b00, Q_HALF});
   assign ws_w    = $signed({2'b00, cent}) - $signed({2'b00, i0_raw, {Q_W{1'b0}}})
                    - $signed({2'b00, Q_HALF});
   assign i0_c    = (i0_raw > src_m1[IDX_W-1:0]) ? src_m1[IDX_W-1:0] : i0_raw;
   assign x1_c    = (x1_raw > src_m1) ? src_m1[IDX_W-1:0] : x1_raw[IDX_W-1:0];

   assign mem_we = (state_ff == ST_CHECK) && (kind_ff == KIND_WRITE);

   always_comb begin
      case (step_ff)
         STEP_W'(0): rd_addr = {v_first_ff, h_first_ff};
         STEP_W'(1): rd_addr = {v_first_ff, h_second_ff};
         STEP_W'(2): rd_addr = {v_second_ff, h_first_ff};
         default:    rd_addr = {v_second_ff, h_second_ff};
      endcase
   end

   always_comb begin
      mul_a = h_wf_ff;
      mul_b = $signed({{(OPB_W-PIX_W){1'b0}}, mem_q_ff});
      case (step_ff)
         STEP_W'(2), STEP_W'(4): mul_a = h_ws_ff;
         STEP_W'(5): begin
            mul_a = v_wf_ff;
            mul_b = top_ff;
         end
         STEP_W'(6): begin
            mul_a = v_ws_ff;
            mul_b = acc_ff[OPB_W-1:0];
         end
         default: mul_a = h_wf_ff;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      h_first_in   = h_first_ff;
      h_second_in  = h_second_ff;
      v_first_in   = v_first_ff;
      v_second_in  = v_second_ff;
      h_wf_in      = h_wf_ff;
      h_ws_in      = h_ws_ff;
      v_wf_in      = v_wf_ff;
      v_ws_in      = v_ws_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      top_in       = top_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (kind_ff == KIND_WRITE) begin
               state_in = ST_IDLE;
            end else if ({1'b0, row_ff} >= th_c || {1'b0, col_ff} >= tw_c) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               axis_in  = 1'b0;
               div_in   = centre_dividend(col_ff, sw_c);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? div_diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            div_in = {div_ff[DIVD_W-2:0], div_ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            if (!axis_ff) begin
               h_first_in  = i0_c;
               h_second_in = x1_c;
               h_wf_in     = wf_w[WGT_W-1:0];
               h_ws_in     = ws_w[WGT_W-1:0];
               axis_in     = 1'b1;
               div_in      = centre_dividend(row_ff, sh_c);
               rem_in      = '0;
               cnt_in      = '0;
               state_in    = ST_DIV;
            end else begin
               v_first_in  = i0_c;
               v_second_in = x1_c;
               v_wf_in     = wf_w[WGT_W-1:0];
               v_ws_in     = ws_w[WGT_W-1:0];
               step_in     = '0;
               state_in    = ST_MAC;
            end
         end
         ST_MAC: begin
            prod_in = mul_p;
            step_in = step_ff + STEP_W'(1);
            case (step_ff)
               STEP_W'(2), STEP_W'(4), STEP_W'(6): begin
                  acc_in = {prod_ff[PROD_W-1], prod_ff};
               end
               STEP_W'(3), STEP_W'(5), STEP_W'(7): begin
                  acc_in = acc_ff + {prod_ff[PROD_W-1], prod_ff};
               end
               default: acc_in = acc_ff;
            endcase
            if (step_ff == STEP_W'(4)) begin
               top_in = acc_ff[OPB_W-1:0];
            end
            if (step_ff == STEP_LAST) begin
               if (acc_ff[ACC_W-1]) begin
                  res_in = '0;
               end else if (acc_ff[ACC_W-1:2*Q_W] > (ACC_W-2*Q_W)'(255)) begin
                  res_in = '1;
               end else begin
                  res_in = acc_ff[2*Q_W+PIX_W-1:2*Q_W];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         step_ff      <= '0;
         sw_ff        <= SIDE_W'(28);
         sh_ff        <= SIDE_W'(28);
         tw_ff        <= SIDE_W'(16);
         th_ff        <= SIDE_W'(16);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               REG_SOURCE_WIDTH:  sw_ff <= csr_wdata;
               REG_SOURCE_HEIGHT: sh_ff <= csr_wdata;
               REG_TARGET_WIDTH:  tw_ff <= csr_wdata;
               REG_TARGET_HEIGHT: th_ff <= csr_wdata;
               default: sw_ff <= sw_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_kind;
         row_ff  <= req_row;
         col_ff  <= req_col;
         pix_ff  <= req_pixel_in;
      end
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      h_first_ff   <= h_first_in;
      h_second_ff  <= h_second_in;
      v_first_ff   <= v_first_in;
      v_second_ff  <= v_second_in;
      h_wf_ff      <= h_wf_in;
      h_ws_ff      <= h_ws_in;
      v_wf_ff      <= v_wf_in;
      v_ws_ff      <= v_ws_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      top_ff       <= top_in;
      res_ff       <= res_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[{row_ff, col_ff}] <= pix_ff;
      end
      mem_q_ff <= store[rd_addr];
   end

   `BIR_ASSERT_NOW(a_rem_below_divisor, clock, reset, state_ff == ST_DIV, rem_ff < divisor)
   `BIR_ASSERT_NOW(a_centre_fits, clock, reset, state_ff == ST_AXIS, div_ff[DIVD_W-1:CENT_W] == '0)
   `BIR_ASSERT_NEXT(a_result_issued, clock, reset, state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == ST_IDLE)

endmodule
